[rtl/rbae_pkg.sv]
// ----------------------------------------------------------------------------
// rbae_pkg
// Shared types and constants for the running block average error block.
// ----------------------------------------------------------------------------
package rbae_pkg;

    localparam int SUM_W  = 48;
    localparam int CNT_W  = 17;
    localparam int DATA_W = 32;
    localparam int ROOT_W = SUM_W / 2;

    localparam logic [CNT_W-1:0] MAX_BLOCKS = 17'h10000;

    typedef struct packed {
        logic signed [DATA_W-1:0] block_mean;
        logic        [DATA_W-1:0] block_mean_sq;
    } t_in;

    typedef struct packed {
        logic signed [DATA_W-1:0] cum_mean;
        logic        [DATA_W-1:0] cum_mean_sq;
        logic        [DATA_W-1:0] uncertainty;
        logic        [CNT_W-1:0]  blocks_seen;
        logic                     full_flag;
    } t_out;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum_means;
        logic        [SUM_W-1:0] sum_squares;
        logic        [CNT_W-1:0] count;
        logic                    full;
    } t_job;

endpackage

[rtl/rbae_front.sv]
// ----------------------------------------------------------------------------
// rbae_front
// Accepts block averages, updates the running sums and block count until the
// count reaches MAX_BLOCKS, and issues a job with the sums for the back end.
// ----------------------------------------------------------------------------
module rbae_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rbae_pkg::t_in    i_data,
    output logic             o_push,
    input  logic             i_space,
    output rbae_pkg::t_job   o_job
);

    logic signed [rbae_pkg::SUM_W-1:0] r_sum_means;
    logic        [rbae_pkg::SUM_W-1:0] r_sum_squares;
    logic        [rbae_pkg::CNT_W-1:0] r_count;
    logic                              w_full;
    logic                              w_take;
    rbae_pkg::t_job                    n_job;

    assign o_ready = i_space;
    assign w_take  = i_valid && i_space;
    assign w_full  = (r_count == rbae_pkg::MAX_BLOCKS);

    always_comb begin
        n_job.full = w_full;
        if (w_full) begin
            n_job.sum_means   = r_sum_means;
            n_job.sum_squares = r_sum_squares;
            n_job.count       = r_count;
        end else begin
            n_job.sum_means   = r_sum_means + {{(rbae_pkg::SUM_W-rbae_pkg::DATA_W)
                                {i_data.block_mean[rbae_pkg::DATA_W-1]}}, i_data.block_mean};
            n_job.sum_squares = r_sum_squares + {{(rbae_pkg::SUM_W-rbae_pkg::DATA_W){1'b0}},
                                i_data.block_mean_sq};
            n_job.count       = r_count + 1'b1;
        end
    end

    assign o_push = w_take;
    assign o_job  = n_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_means   <= '0;
            r_sum_squares <= '0;
            r_count       <= '0;
        end else if (w_take) begin
            r_sum_means   <= n_job.sum_means;
            r_sum_squares <= n_job.sum_squares;
            r_count       <= n_job.count;
        end
    end

endmodule

[rtl/rbae_fifo.sv]
// ----------------------------------------------------------------------------
// rbae_fifo
// Two-entry job queue between the front end and the back end.
// ----------------------------------------------------------------------------
module rbae_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rbae_pkg::t_job   i_job,
    output logic             o_space,
    input  logic             i_pop,
    output logic             o_avail,
    output rbae_pkg::t_job   o_job
);

    rbae_pkg::t_job r_mem [2];
    logic           r_wptr;
    logic           r_rptr;
    logic [1:0]     r_fill;

    assign o_space = (r_fill != 2'd2);
    assign o_avail = (r_fill != 2'd0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_fill <= r_fill + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

[rtl/rbae_div.sv]
// ----------------------------------------------------------------------------
// rbae_div
// Restoring divider, one quotient bit per cycle, for a sum by a block count.
// ----------------------------------------------------------------------------
module rbae_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [rbae_pkg::SUM_W-1:0] i_dividend,
    input  logic [rbae_pkg::CNT_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [rbae_pkg::SUM_W-1:0] o_quot
);

    logic [rbae_pkg::SUM_W-1:0] r_dq;
    logic [rbae_pkg::CNT_W:0]   r_rem;
    logic [rbae_pkg::CNT_W-1:0] r_dvs;
    logic [5:0]                 r_cnt;
    logic                       r_busy;
    logic                       r_done;
    logic [rbae_pkg::CNT_W:0]   w_sh;
    logic                       w_ge;

    assign w_sh   = {r_rem[rbae_pkg::CNT_W-1:0], r_dq[rbae_pkg::SUM_W-1]};
    assign w_ge   = (w_sh >= {1'b0, r_dvs});
    assign o_done = r_done;
    assign o_quot = r_dq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 6'(rbae_pkg::SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dq  <= i_dividend;
            r_dvs <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dq  <= {r_dq[rbae_pkg::SUM_W-2:0], w_ge};
            r_rem <= w_ge ? (w_sh - {1'b0, r_dvs}) : w_sh;
        end
    end

endmodule

[rtl/rbae_sqrt.sv]
// ----------------------------------------------------------------------------
// rbae_sqrt
// Bit-serial integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module rbae_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [rbae_pkg::SUM_W-1:0]  i_rad,
    output logic                        o_done,
    output logic [rbae_pkg::ROOT_W-1:0] o_root
);

    logic [rbae_pkg::SUM_W-1:0]  r_rad;
    logic [rbae_pkg::ROOT_W+1:0] r_rem;
    logic [rbae_pkg::ROOT_W-1:0] r_root;
    logic [4:0]                  r_cnt;
    logic                        r_busy;
    logic                        r_done;
    logic [rbae_pkg::ROOT_W+1:0] w_sh;
    logic [rbae_pkg::ROOT_W+1:0] w_trial;
    logic                        w_ge;

    assign w_sh    = {r_rem[rbae_pkg::ROOT_W-1:0], r_rad[rbae_pkg::SUM_W-1 -: 2]};
    assign w_trial = {r_root, 2'b01};
    assign w_ge    = (w_sh >= w_trial);
    assign o_done  = r_done;
    assign o_root  = r_root;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == 5'(rbae_pkg::ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[rbae_pkg::SUM_W-3:0], 2'b00};
            r_rem  <= w_ge ? (w_sh - w_trial) : w_sh;
            r_root <= {r_root[rbae_pkg::ROOT_W-2:0], w_ge};
        end
    end

endmodule

[rtl/rbae_back.sv]
// ----------------------------------------------------------------------------
// rbae_back
// Sequencer that turns queued sums into the cumulative mean, mean of squares
// and standard error, and holds the result in the output register.
// ----------------------------------------------------------------------------
module rbae_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_avail,
    input  rbae_pkg::t_job   i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output rbae_pkg::t_out   o_data
);

    typedef enum logic [2:0] {
        S_IDLE, S_DIV1, S_MUL, S_VAR, S_DIV2, S_SQRT, S_DONE
    } t_state;

    t_state                        r_state;
    logic [rbae_pkg::CNT_W-1:0]    r_k;
    logic                          r_full;
    logic                          r_neg;
    logic [rbae_pkg::DATA_W-1:0]   r_mag;
    logic [rbae_pkg::DATA_W-1:0]   r_cmsq;
    logic [46:0]                   r_sq;
    logic [rbae_pkg::ROOT_W-1:0]   r_unc;
    logic                          r_out_valid;
    rbae_pkg::t_out                r_out;

    logic                          w_start0;
    logic                          w_start1;
    logic                          w_sqrt_start;
    logic [rbae_pkg::SUM_W-1:0]    w_dvd0;
    logic [rbae_pkg::CNT_W-1:0]    w_dvs0;
    logic [rbae_pkg::SUM_W-1:0]    w_abs;
    logic                          w_done0;
    logic                          w_done1;
    logic                          w_sqrt_done;
    logic [rbae_pkg::SUM_W-1:0]    w_q0;
    logic [rbae_pkg::SUM_W-1:0]    w_q1;
    logic [rbae_pkg::ROOT_W-1:0]   w_root;
    logic [63:0]                   w_prod;
    logic                          w_var_pos;
    logic [rbae_pkg::DATA_W-1:0]   n_var;
    logic [rbae_pkg::DATA_W-1:0]   n_mean;

    assign w_abs = i_job.sum_means[rbae_pkg::SUM_W-1] ? (-i_job.sum_means) : i_job.sum_means;
    assign w_var_pos = (r_k > 17'd1) && ({15'd0, r_cmsq} > r_sq);
    assign n_var = r_cmsq - r_sq[rbae_pkg::DATA_W-1:0];
    assign w_prod = r_mag * r_mag;
    assign n_mean = r_neg ? (-r_mag) : r_mag;

    assign o_pop        = (r_state == S_IDLE) && i_avail;
    assign w_start0     = o_pop || ((r_state == S_VAR) && w_var_pos);
    assign w_start1     = o_pop;
    assign w_sqrt_start = (r_state == S_DIV2) && w_done0;

    always_comb begin
        if (r_state == S_IDLE) begin
            w_dvd0 = w_abs;
            w_dvs0 = i_job.count;
        end else begin
            w_dvd0 = {{(rbae_pkg::SUM_W-rbae_pkg::DATA_W){1'b0}}, n_var};
            w_dvs0 = r_k - 1'b1;
        end
    end

    rbae_div u_div0 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start0),
        .i_dividend (w_dvd0),
        .i_divisor  (w_dvs0),
        .o_done     (w_done0),
        .o_quot     (w_q0)
    );

    rbae_div u_div1 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start1),
        .i_dividend (i_job.sum_squares),
        .i_divisor  (i_job.count),
        .o_done     (w_done1),
        .o_quot     (w_q1)
    );

    rbae_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sqrt_start),
        .i_rad   ({w_q0[rbae_pkg::DATA_W-1:0], 16'd0}),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_avail) begin
                        r_k     <= i_job.count;
                        r_full  <= i_job.full;
                        r_neg   <= i_job.sum_means[rbae_pkg::SUM_W-1];
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (w_done0 && w_done1) begin
                        r_mag   <= w_q0[rbae_pkg::DATA_W-1:0];
                        r_cmsq  <= w_q1[rbae_pkg::DATA_W-1:0];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_sq    <= w_prod[62:16];
                    r_state <= S_VAR;
                end
                S_VAR: begin
                    r_unc <= '0;
                    if (w_var_pos) begin
                        r_state <= S_DIV2;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DIV2: begin
                    if (w_done0) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (w_sqrt_done) begin
                        r_unc   <= w_root;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_ready) begin
                        r_out.cum_mean    <= n_mean;
                        r_out.cum_mean_sq <= r_cmsq;
                        r_out.uncertainty <= {{(rbae_pkg::DATA_W-rbae_pkg::ROOT_W){1'b0}}, r_unc};
                        r_out.blocks_seen <= r_k;
                        r_out.full_flag   <= r_full;
                        r_out_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_mul_to_var: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL |=> r_state == S_VAR)
        else $error("multiply step not followed by variance step");

    a_first_unc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.blocks_seen == 17'd1) |-> r_out.uncertainty == '0)
        else $error("non-zero uncertainty for the first block");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.full_flag) |-> r_out.blocks_seen == rbae_pkg::MAX_BLOCKS)
        else $error("full flag without a full count");

endmodule

[rtl/running_block_average_error.sv]
// ----------------------------------------------------------------------------
// running_block_average_error
// Running blocking-method statistics: cumulative mean, mean of squares and
// standard error of the mean over the blocks received so far.
//
//   channel  direction  handshake          payload
//   input    in         i_valid/o_ready    i_data (t_in)
//   result   out        o_valid/i_ready    o_data (t_out)
//
// After its input transfer, each item passes through the queue, the two
// parallel divisions, the multiply and the variance step; a second division
// and the square root follow when the variance is positive and more than one
// block is held. Reset clears the sums, the count and the queue.
// The front end keeps accepting while the two-entry queue has space, and the
// back end finishes a result while the previous one waits in the output
// register.
// ----------------------------------------------------------------------------
module running_block_average_error (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  rbae_pkg::t_in    i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output rbae_pkg::t_out   o_data
);

    logic           w_push;
    logic           w_space;
    logic           w_pop;
    logic           w_avail;
    rbae_pkg::t_job w_job_in;
    rbae_pkg::t_job w_job_out;

    rbae_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_push  (w_push),
        .i_space (w_space),
        .o_job   (w_job_in)
    );

    rbae_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_space (w_space),
        .i_pop   (w_pop),
        .o_avail (w_avail),
        .o_job   (w_job_out)
    );

    rbae_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (w_avail),
        .i_job   (w_job_out),
        .o_pop   (w_pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

endmodule
